@@ rtl/sbus_frame_decoder_macros.svh @@
// Assertion helpers shared by the decoder RTL.
`ifndef SBUS_FRAME_DECODER_MACROS_SVH
`define SBUS_FRAME_DECODER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SBUS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sbus_frame_decoder: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define SBUS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sbus_frame_decoder: next-cycle check failed");

`endif

@@ rtl/sbus_pkg.sv @@
`default_nettype none

package sbus_pkg;

  localparam int unsigned NUM_CH   = 16;
  localparam int unsigned CH_BITS  = 11;
  localparam int unsigned CH_IDX_W = 4;
  localparam int unsigned ACC_W    = 18;
  localparam int unsigned BCNT_W   = 5;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned CFG_AW   = 4;

  localparam logic [7:0]         HEADER_BYTE = 8'h0F;
  localparam logic [7:0]         FOOTER_BYTE = 8'h00;
  localparam logic [POS_W-1:0]   POS_IDLE    = 5'd25;
  localparam logic [POS_W-1:0]   POS_LAST_PL = 5'd22;
  localparam logic [POS_W-1:0]   POS_FLAGS   = 5'd23;
  localparam logic [POS_W-1:0]   POS_FOOTER  = 5'd24;

  localparam logic [CH_BITS-1:0] LOW_RESET    = 11'd682;
  localparam logic [CH_BITS-1:0] HIGH_RESET   = 11'd1364;
  localparam logic [CH_BITS-1:0] TOGGLE_RESET = 11'd1024;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_SWITCH_LOW  = 2'd0;
  localparam logic [1:0] REG_SWITCH_HIGH = 2'd1;
  localparam logic [1:0] REG_TOGGLE      = 2'd2;

  // Switch position codes
  localparam logic [1:0] SW_DOWN   = 2'd0;
  localparam logic [1:0] SW_MIDDLE = 2'd1;
  localparam logic [1:0] SW_UP     = 2'd2;

  typedef enum logic {
    ST_RECV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } in_t;

  typedef struct packed {
    logic [3:0]  channel_index;
    logic [10:0] channel_value;
    logic [11:0] scaled_value;
    logic [1:0]  switch_position;
    logic        switch_on;
    logic        digital_a;
    logic        digital_b;
    logic        lost_frame;
    logic        fail_safe;
    logic        frame_valid;
    logic        last_result;
  } out_t;

endpackage

`default_nettype wire

@@ rtl/sbus_frame_decoder.sv @@
`default_nettype none
// SBUS frame decoder. Bytes of a 25-byte frame enter one per cycle on the in_ channel,
// with frame_start marking the header byte; a new frame_start always restarts the frame.
// Payload bytes are unpacked into sixteen 11-bit channels on the fly, and a frame with
// header 0x0F and footer 0x00 replaces the held channels and flags. Each footer byte
// releases 16 results, one per cycle while out_ready stays high, all decoded by one
// shared threshold-compare unit stepped by a channel counter. in_ready is low while
// those results are loaded and stays low while the output stalls. Thresholds are
// written over the APB port at 0x0, 0x4 and 0x8 and should only change while no frame
// is open.
`include "sbus_frame_decoder_macros.svh"

module sbus_frame_decoder (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire sbus_pkg::in_t in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output sbus_pkg::out_t     out_data,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [sbus_pkg::CFG_AW-1:0] paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  import sbus_pkg::*;

  state_t              state_r, state_nxt;
  logic [POS_W-1:0]    pos_r;
  logic                header_good_r;
  logic [ACC_W-1:0]    acc_r;
  logic [BCNT_W-1:0]   bcnt_r;
  logic [CH_IDX_W-1:0] wr_idx_r;
  logic [CH_BITS-1:0]  staged_r [NUM_CH];
  logic [3:0]          staged_flags_r;
  logic [CH_BITS-1:0]  held_r [NUM_CH];
  logic [3:0]          held_flags_r;
  logic                frame_valid_r;
  logic [CH_IDX_W-1:0] emit_idx_r;
  logic                out_valid_r;
  out_t                out_data_r;
  logic [CH_BITS-1:0]  low_r, high_r, toggle_r;

  logic                in_acc;
  logic                footer_acc;
  logic                emit_load;
  logic                good_frame;
  logic [ACC_W-1:0]    acc_sum;
  logic [BCNT_W-1:0]   bcnt_sum;
  logic                ch_done;
  logic                cfg_wr;

  logic [CH_BITS-1:0]  cmp_val;
  logic [1:0]          cmp_sw;
  logic                cmp_on;

  assign in_acc     = in_valid && in_ready;
  assign footer_acc = in_acc && !in_data.frame_start && (pos_r == POS_FOOTER);
  assign good_frame = header_good_r && (in_data.rx_byte == FOOTER_BYTE);

  assign acc_sum  = acc_r | (ACC_W'(in_data.rx_byte) << bcnt_r);
  assign bcnt_sum = bcnt_r + BCNT_W'(8);
  assign ch_done  = bcnt_sum >= BCNT_W'(CH_BITS);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_RECV: if (footer_acc) state_nxt = ST_EMIT;
      ST_EMIT: if (emit_load && (emit_idx_r == CH_IDX_W'(NUM_CH - 1))) state_nxt = ST_RECV;
      default: state_nxt = ST_RECV;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_ready  = 1'b0;
    emit_load = 1'b0;
    case (state_r)
      ST_RECV: in_ready = 1'b1;
      ST_EMIT: emit_load = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_RECV;
    else        state_r <= state_nxt;
  end

  // Frame reception
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r          <= POS_IDLE;
      header_good_r  <= 1'b0;
      acc_r          <= '0;
      bcnt_r         <= '0;
      wr_idx_r       <= '0;
      staged_flags_r <= '0;
      held_flags_r   <= '0;
      frame_valid_r  <= 1'b0;
      for (int i = 0; i < NUM_CH; i++) held_r[i] <= '0;
    end else if (in_acc) begin
      if (in_data.frame_start) begin
        header_good_r <= (in_data.rx_byte == HEADER_BYTE);
        acc_r         <= '0;
        bcnt_r        <= '0;
        wr_idx_r      <= '0;
        pos_r         <= POS_W'(1);
      end else if (pos_r != '0 && pos_r <= POS_LAST_PL) begin
        pos_r <= pos_r + POS_W'(1);
        if (ch_done) begin
          acc_r    <= acc_sum >> CH_BITS;
          bcnt_r   <= bcnt_sum - BCNT_W'(CH_BITS);
          wr_idx_r <= wr_idx_r + CH_IDX_W'(1);
        end else begin
          acc_r  <= acc_sum;
          bcnt_r <= bcnt_sum;
        end
      end else if (pos_r == POS_FLAGS) begin
        staged_flags_r <= in_data.rx_byte[3:0];
        pos_r          <= POS_FOOTER;
      end else if (pos_r == POS_FOOTER) begin
        pos_r         <= POS_IDLE;
        frame_valid_r <= good_frame;
        if (good_frame) begin
          held_flags_r <= staged_flags_r;
          for (int i = 0; i < NUM_CH; i++) held_r[i] <= staged_r[i];
        end
      end
    end
  end

  // Staged channel store, no reset: every entry is written before a footer
  always_ff @(posedge clk) begin
    if (in_acc && !in_data.frame_start && pos_r != '0 && pos_r <= POS_LAST_PL && ch_done)
      staged_r[wr_idx_r] <= acc_sum[CH_BITS-1:0];
  end

  // Shared threshold-compare unit
  always_comb begin
    cmp_val = held_r[emit_idx_r];
    if (cmp_val < low_r)       cmp_sw = SW_DOWN;
    else if (cmp_val > high_r) cmp_sw = SW_UP;
    else                       cmp_sw = SW_MIDDLE;
    cmp_on = cmp_val > toggle_r;
  end

  // Result burst
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (footer_acc) emit_idx_r <= '0;
      else if (emit_load) emit_idx_r <= emit_idx_r + CH_IDX_W'(1);
      if (emit_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_data_r.channel_index   <= emit_idx_r;
      out_data_r.channel_value   <= cmp_val;
      out_data_r.scaled_value    <= {cmp_val, 1'b0};
      out_data_r.switch_position <= cmp_sw;
      out_data_r.switch_on       <= cmp_on;
      out_data_r.digital_a       <= held_flags_r[0];
      out_data_r.digital_b       <= held_flags_r[1];
      out_data_r.lost_frame      <= held_flags_r[2];
      out_data_r.fail_safe       <= held_flags_r[3];
      out_data_r.frame_valid     <= frame_valid_r;
      out_data_r.last_result     <= (emit_idx_r == CH_IDX_W'(NUM_CH - 1));
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r    <= LOW_RESET;
      high_r   <= HIGH_RESET;
      toggle_r <= TOGGLE_RESET;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_SWITCH_LOW:  low_r    <= pwdata[CH_BITS-1:0];
        REG_SWITCH_HIGH: high_r   <= pwdata[CH_BITS-1:0];
        REG_TOGGLE:      toggle_r <= pwdata[CH_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SWITCH_LOW:  prdata = 32'(low_r);
      REG_SWITCH_HIGH: prdata = 32'(high_r);
      REG_TOGGLE:      prdata = 32'(toggle_r);
      default:         prdata = '0;
    endcase
  end

  // Checks
  `SBUS_ASSERT_IMP(a_bcnt_range, 1'b1, bcnt_r < BCNT_W'(CH_BITS))
  `SBUS_ASSERT_IMP(a_emit_idle_pos, state_r == ST_EMIT, pos_r == POS_IDLE)
  `SBUS_ASSERT_IMP(a_on_matches, out_valid_r && out_data_r.switch_on,
                   out_data_r.channel_value > toggle_r)
  `SBUS_ASSERT_NXT(a_burst_ends, out_valid_r && out_ready && out_data_r.last_result,
                   !out_valid_r || (out_data_r.channel_index == CH_IDX_W'(0)))
  `SBUS_ASSERT_NXT(a_burst_steps, out_valid_r && out_ready && !out_data_r.last_result,
                   out_valid_r && (out_data_r.channel_index ==
                   $past(out_data_r.channel_index) + CH_IDX_W'(1)))

endmodule

`default_nettype wire

@@ tb/sbus_frame_decoder_tb.sv @@
`timescale 1ns / 100ps

module sbus_frame_decoder_tb;
  import sbus_pkg::*;

  localparam int PAYLOAD_W       = NUM_CH * CH_BITS;
  localparam int PAYLOAD_BYTES   = PAYLOAD_W / 8;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int HOLD_CYCLES     = 300;
  localparam int SETTLE_CYCLES   = 20;
  localparam int IDLE_PCT        = 37;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef enum {
    SEQ_GOOD,
    SEQ_BAD_HEADER,
    SEQ_BAD_FOOTER,
    SEQ_RESTART,
    SEQ_NOISE
  } frame_kind_t;

  class frame_result_checker;
    logic [POS_W-1:0]     byte_pos;
    logic                 header_ok;
    logic [PAYLOAD_W-1:0] staged_bits;
    logic [3:0]           staged_flags;
    logic [CH_BITS-1:0]   held_ch [NUM_CH];
    logic [3:0]           held_flags;
    logic [CH_BITS-1:0]   low_limit;
    logic [CH_BITS-1:0]   high_limit;
    logic [CH_BITS-1:0]   toggle_limit;
    out_t                 expected_channels [$];
    int                   errors;
    int                   results_checked;
    int                   frames_kept;
    int                   frames_rejected;

    function new();
      byte_pos = POS_IDLE;
      header_ok = 1'b0;
      staged_bits = '0;
      staged_flags = '0;
      foreach (held_ch[k]) held_ch[k] = '0;
      held_flags = '0;
      low_limit = LOW_RESET;
      high_limit = HIGH_RESET;
      toggle_limit = TOGGLE_RESET;
      errors = 0;
      results_checked = 0;
      frames_kept = 0;
      frames_rejected = 0;
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("mismatch: %s", msg);
    endfunction

    function int pending();
      return expected_channels.size();
    endfunction

    function void set_limit(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_SWITCH_LOW:  low_limit = value[CH_BITS-1:0];
        REG_SWITCH_HIGH: high_limit = value[CH_BITS-1:0];
        REG_TOGGLE:      toggle_limit = value[CH_BITS-1:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] limit_of(logic [1:0] idx);
      case (idx)
        REG_SWITCH_LOW:  return 32'(low_limit);
        REG_SWITCH_HIGH: return 32'(high_limit);
        default:         return 32'(toggle_limit);
      endcase
    endfunction

    // Advance the frame state by one accepted byte; the footer releases 16 results.
    function void note_request(in_t req);
      logic good;
      out_t r;
      logic [CH_BITS-1:0] v;
      if (req.frame_start) begin
        header_ok = (req.rx_byte == HEADER_BYTE);
        byte_pos = 5'd1;
        return;
      end
      if (byte_pos == 5'd0 || byte_pos >= POS_IDLE) return;
      if (byte_pos <= POS_LAST_PL) begin
        staged_bits[8*(int'(byte_pos)-1) +: 8] = req.rx_byte;
        byte_pos++;
        return;
      end
      if (byte_pos == POS_FLAGS) begin
        staged_flags = req.rx_byte[3:0];
        byte_pos++;
        return;
      end
      byte_pos = POS_IDLE;
      good = header_ok && (req.rx_byte == FOOTER_BYTE);
      if (good) begin
        for (int k = 0; k < NUM_CH; k++) held_ch[k] = staged_bits[CH_BITS*k +: CH_BITS];
        held_flags = staged_flags;
        frames_kept++;
      end else begin
        frames_rejected++;
      end
      for (int k = 0; k < NUM_CH; k++) begin
        v = held_ch[k];
        r.channel_index = k[CH_IDX_W-1:0];
        r.channel_value = v;
        r.scaled_value = {v, 1'b0};
        if (v < low_limit) r.switch_position = SW_DOWN;
        else if (v > high_limit) r.switch_position = SW_UP;
        else r.switch_position = SW_MIDDLE;
        r.switch_on = (v > toggle_limit);
        r.digital_a = held_flags[0];
        r.digital_b = held_flags[1];
        r.lost_frame = held_flags[2];
        r.fail_safe = held_flags[3];
        r.frame_valid = good;
        r.last_result = (k == NUM_CH - 1);
        expected_channels.push_back(r);
      end
    endfunction

    function string describe(out_t r);
      return $sformatf("ch %0d val %0d x2 %0d sw %0d on %b flags %b%b%b%b valid %b last %b",
                       r.channel_index, r.channel_value, r.scaled_value, r.switch_position,
                       r.switch_on, r.fail_safe, r.lost_frame, r.digital_b, r.digital_a,
                       r.frame_valid, r.last_result);
    endfunction

    function void check_result(out_t got);
      out_t want;
      string diff;
      if (expected_channels.size() == 0) begin
        flag({"result with nothing expected: ", describe(got)});
        return;
      end
      want = expected_channels.pop_front();
      results_checked++;
      diff = "";
      if (got.channel_index !== want.channel_index) diff = {diff, " channel_index"};
      if (got.channel_value !== want.channel_value) diff = {diff, " channel_value"};
      if (got.scaled_value !== want.scaled_value) diff = {diff, " scaled_value"};
      if (got.switch_position !== want.switch_position) diff = {diff, " switch_position"};
      if (got.switch_on !== want.switch_on) diff = {diff, " switch_on"};
      if (got.digital_a !== want.digital_a) diff = {diff, " digital_a"};
      if (got.digital_b !== want.digital_b) diff = {diff, " digital_b"};
      if (got.lost_frame !== want.lost_frame) diff = {diff, " lost_frame"};
      if (got.fail_safe !== want.fail_safe) diff = {diff, " fail_safe"};
      if (got.frame_valid !== want.frame_valid) diff = {diff, " frame_valid"};
      if (got.last_result !== want.last_result) diff = {diff, " last_result"};
      if (diff != "")
        flag({"field", diff, ": expected ", describe(want), " / got ", describe(got)});
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_t         in_data;
  logic        out_valid;
  logic        out_ready;
  out_t        out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  logic        tx_gaps;
  logic        rx_gaps;
  logic        hold_req;
  int          quiet_cycles;
  int          settings_used;
  logic [CH_BITS-1:0] corner_vals [NUM_CH];

  frame_result_checker book = new();

  sbus_frame_decoder i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: random stalls, or one long hold-off when requested.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_ready = !rx_gaps || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) book.note_request(in_data);
      if (out_valid && out_ready) book.check_result(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no request moved for %0d cycles", WATCHDOG_LIMIT);
        $display("FAIL sbus_frame_decoder");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic st);
    while (tx_gaps && $urandom_range(99) < IDLE_PCT) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_data.rx_byte = b;
    in_data.frame_start = st;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_frame(input logic [7:0] hdr, input logic [PAYLOAD_W-1:0] payload,
                            input logic [7:0] flags, input logic [7:0] ftr);
    send_byte(hdr, 1'b1);
    for (int i = 0; i < PAYLOAD_BYTES; i++) send_byte(payload[8*i +: 8], 1'b0);
    send_byte(flags, 1'b0);
    send_byte(ftr, 1'b0);
  endtask

  // Bias channel values toward the extremes and the decode thresholds.
  function automatic logic [PAYLOAD_W-1:0] random_payload();
    logic [PAYLOAD_W-1:0] p;
    logic [CH_BITS-1:0] v;
    for (int k = 0; k < NUM_CH; k++) begin
      case ($urandom_range(5))
        0: v = '0;
        1: v = '1;
        2: v = book.low_limit + CH_BITS'($urandom_range(2)) - 11'd1;
        3: v = book.high_limit + CH_BITS'($urandom_range(2)) - 11'd1;
        4: v = book.toggle_limit + CH_BITS'($urandom_range(2)) - 11'd1;
        default: v = CH_BITS'($urandom_range(2047));
      endcase
      p[CH_BITS*k +: CH_BITS] = v;
    end
    return p;
  endfunction

  task automatic send_seq(input frame_kind_t kind);
    logic [7:0] b;
    case (kind)
      SEQ_GOOD:
        send_frame(HEADER_BYTE, random_payload(), 8'($urandom_range(255)), FOOTER_BYTE);
      SEQ_BAD_HEADER: begin
        do b = 8'($urandom_range(255)); while (b == HEADER_BYTE);
        send_frame(b, random_payload(), 8'($urandom_range(255)), FOOTER_BYTE);
      end
      SEQ_BAD_FOOTER:
        send_frame(HEADER_BYTE, random_payload(), 8'($urandom_range(255)),
                   8'($urandom_range(1, 255)));
      SEQ_RESTART: begin
        // drop a partial frame, up to the footer position, then send a full one
        send_byte($urandom_range(1) ? HEADER_BYTE : 8'($urandom_range(255)), 1'b1);
        repeat ($urandom_range(0, 23)) send_byte(8'($urandom_range(255)), 1'b0);
        send_frame(HEADER_BYTE, random_payload(), 8'($urandom_range(255)), FOOTER_BYTE);
      end
      default:
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)), 1'b0);
    endcase
  endtask

  // Hold the sender until every expected result has arrived, then let the block settle.
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    book.set_limit(idx, value);
    if (idx != REG_UNUSED) begin
      @(negedge clk);
      psel = 1'b1;
      paddr = {idx, 2'b00};
      @(negedge clk);
      penable = 1'b1;
      @(posedge clk);
      if (prdata !== book.limit_of(idx))
        book.flag($sformatf("register %0d read %0d, expected %0d", idx, prdata,
                            book.limit_of(idx)));
      @(negedge clk);
      psel = 1'b0;
      penable = 1'b0;
    end
  endtask

  task automatic set_limits(input logic [31:0] low, input logic [31:0] high,
                            input logic [31:0] toggle);
    write_limit(REG_SWITCH_LOW, low);
    write_limit(REG_SWITCH_HIGH, high);
    write_limit(REG_TOGGLE, toggle);
    settings_used++;
  endtask

  initial begin
    logic [PAYLOAD_W-1:0] corner;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    hold_req = 1'b0;
    quiet_cycles = 0;
    settings_used = 1;
    corner_vals = '{11'd0, 11'd2047, 11'd681, 11'd682, 11'd683, 11'd1363, 11'd1364,
                    11'd1365, 11'd1023, 11'd1024, 11'd1025, 11'd1, 11'd2046, 11'h555,
                    11'h2AA, 11'd1024};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // idle bytes before any frame, then one frame of corner values, no idling on either side
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    for (int k = 0; k < NUM_CH; k++) corner[CH_BITS*k +: CH_BITS] = corner_vals[k];
    send_frame(HEADER_BYTE, corner, 8'hFA, FOOTER_BYTE);
    drain();
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;

    // crossed limits: low above high, decoded on the held corner values
    set_limits(32'd2047, 32'd0, 32'd0);
    send_seq(SEQ_BAD_FOOTER);
    drain();

    // wide write data gets masked; the unused slot must not disturb anything
    set_limits($urandom(), $urandom(), $urandom());
    write_limit(REG_UNUSED, $urandom());
    send_seq(SEQ_RESTART);
    drain();

    // stall the result side long enough that frame intake backs up
    set_limits(32'($urandom_range(2047)), 32'($urandom_range(2047)),
               32'($urandom_range(2047)));
    hold_req = 1'b1;
    send_seq(SEQ_BAD_HEADER);
    send_seq(SEQ_NOISE);
    drain();

    if (book.pending() != 0)
      book.flag($sformatf("%0d expected results never arrived", book.pending()));
    $display("covered %0d frames taken, %0d rejected, over %0d threshold settings",
             book.frames_kept, book.frames_rejected, settings_used);
    $display("checked %0d channel results, %0d errors", book.results_checked, book.errors);
    if (book.errors == 0) begin
      $display("PASS sbus_frame_decoder");
    end else begin
      $display("FAIL sbus_frame_decoder");
    end
    $finish;
  end

endmodule
